// File: design/hpl_pkg.sv
package hpl_pkg;

  // pipeline depth, input register to output register
  localparam int STAGES = 13;

  // configuration register indexes
  localparam logic [2:0] REG_FREQ   = 3'd0;
  localparam logic [2:0] REG_HB     = 3'd1;
  localparam logic [2:0] REG_HM     = 3'd2;
  localparam logic [2:0] REG_MIN    = 3'd3;
  localparam logic [2:0] REG_SHADOW = 3'd4;

  // reset values
  localparam logic [10:0] FREQ_RST   = 11'd1800;
  localparam logic [14:0] HB_RST     = 15'd500;
  localparam logic [9:0]  HM_RST     = 10'd150;
  localparam logic [15:0] MIN_RST    = 16'd50;
  localparam logic [13:0] SHADOW_RST = 14'd2560;

  // log10(2) in q32
  localparam logic [30:0] LOG10_2_Q32 = 31'd1292913987;

  // reciprocal multipliers for divide by 100
  localparam logic [20:0] RECIP100_20 = 21'd1342178;   // 20-bit dividend, shift 27
  localparam logic [27:0] RECIP100_27 = 28'd171798692; // 27-bit dividend, shift 34

  // fraction of log2 from a q30 mantissa by repeated squaring
  function automatic logic [16:0] frac_sq(input longint unsigned m0);
    longint unsigned m;
    logic [16:0] r;
    m = m0;
    r = '0;
    for (int b = 15; b >= 0; b--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        r[b] = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

// File: design/hata_path_loss_rx_power.sv
// channel  | handshake             | word
// ---------+-----------------------+-----------------------------------
// input    | in_valid / in_stall   | dist_cm, tx_power
// output   | out_valid / out_stall | rx_power, loss_q8, too_close
// config   | cfg_wr                | cfg_addr, cfg_data (no read-back)
//
// one word in and one word out per cycle while out_stall is low, 13 register
// stages from the input register to the output register
// the log10 units take 4 of the 13 register stages and the reciprocal
// divides by 100 each have their own multiplier stage
// the input stalls only when every stage holds a word and out_stall is high
// reset restores register defaults and empties the pipeline
module hata_path_loss_rx_power #(
  parameter int DIST_BITS       = 24,
  parameter int LOG_TABLE_DEPTH = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [DIST_BITS-1:0]        dist_cm,
  input  logic signed [15:0]          tx_power,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [17:0]          rx_power,
  output logic [15:0]                 loss_q8,
  output logic                        too_close,
  input  logic                        cfg_wr,
  input  logic [2:0]                  cfg_addr,
  input  logic [15:0]                 cfg_data
);

  localparam int S   = hpl_pkg::STAGES;
  localparam int LWF = $clog2(11) + 17;
  localparam int LWB = $clog2(15) + 17;
  localparam int LWD = $clog2(DIST_BITS) + 17;

  // configuration registers
  logic [10:0] freq_mhz;
  logic [14:0] base_height_cm;
  logic [9:0]  mobile_height_cm;
  logic [15:0] min_dist_cm;
  logic [13:0] shadow_margin;

  always_ff @(posedge clk) begin
    if (rst) begin
      freq_mhz         <= hpl_pkg::FREQ_RST;
      base_height_cm   <= hpl_pkg::HB_RST;
      mobile_height_cm <= hpl_pkg::HM_RST;
      min_dist_cm      <= hpl_pkg::MIN_RST;
      shadow_margin    <= hpl_pkg::SHADOW_RST;
    end else if (cfg_wr) begin
      case (cfg_addr)
        hpl_pkg::REG_FREQ:   freq_mhz         <= cfg_data[10:0];
        hpl_pkg::REG_HB:     base_height_cm   <= cfg_data[14:0];
        hpl_pkg::REG_HM:     mobile_height_cm <= cfg_data[9:0];
        hpl_pkg::REG_MIN:    min_dist_cm      <= cfg_data;
        hpl_pkg::REG_SHADOW: shadow_margin    <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  // pipeline enables
  logic [S:1] en;

  hpl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .en        (en)
  );

  // stage 1: input register, too-close test; tx and flag ride along
  logic [DIST_BITS-1:0] s1_dist;
  logic signed [15:0]   tx_d [1:S-1];
  logic                 tc_d [1:S-1];
  logic                 tc_w;

  assign tc_w = dist_cm <= DIST_BITS'(min_dist_cm);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_dist <= dist_cm;
      tx_d[1] <= tx_power;
      tc_d[1] <= tc_w;
    end
    for (int k = 2; k <= S - 1; k++) begin
      if (en[k]) begin
        tx_d[k] <= tx_d[k-1];
        tc_d[k] <= tc_d[k-1];
      end
    end
  end

  // stages 2 to 5: three log10 units in q16
  logic [LWF-1:0] lg_f;
  logic [LWB-1:0] lg_b;
  logic [LWD-1:0] lg_d;

  hpl_log10 #(.XW(11), .DEPTH(LOG_TABLE_DEPTH)) u_log_f (
    .clk (clk), .en (en[5:2]), .x (freq_mhz), .lg (lg_f)
  );

  hpl_log10 #(.XW(15), .DEPTH(LOG_TABLE_DEPTH)) u_log_b (
    .clk (clk), .en (en[5:2]), .x (base_height_cm), .lg (lg_b)
  );

  hpl_log10 #(.XW(DIST_BITS), .DEPTH(LOG_TABLE_DEPTH)) u_log_d (
    .clk (clk), .en (en[5:2]), .x (s1_dist), .lg (lg_d)
  );

  // stage 6: coefficient terms, sum in units of 1/(100*65536) dB
  logic signed [39:0] lf_w, lhb_w, ld_w, x_w, y_w, t1_w;
  logic signed [26:0] s6_x;
  logic signed [29:0] s6_y;
  logic signed [32:0] s6_t1;
  logic signed [20:0] s6_ld;

  always_comb begin
    lf_w  = signed'(40'(lg_f));
    lhb_w = signed'(40'(lg_b)) - 40'sd131072;
    ld_w  = signed'(40'(lg_d)) - 40'sd327680;
    // 1.11*log f - 0.7
    x_w   = 40'sd111 * lf_w - 40'sd4587520;
    // 44.9 - 6.55*log hb
    y_w   = 40'sd294256640 - 40'sd655 * lhb_w;
    // 46.3 - 0.8 + (33.9 + 1.56)*log f - 13.82*log hb + shadow
    t1_w  = 40'sd298188800 + 40'sd3546 * lf_w - 40'sd1382 * lhb_w
            + 40'sd25600 * signed'(40'(shadow_margin));
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_x  <= x_w[26:0];
      s6_y  <= y_w[29:0];
      s6_t1 <= t1_w[32:0];
      s6_ld <= ld_w[20:0];
    end
  end

  // stage 7: mobile height product (biased positive) and distance term
  logic signed [40:0] a_w;
  logic signed [50:0] dp_w;
  logic [39:0]        s7_u;
  logic signed [34:0] s7_dt;
  logic signed [32:0] s7_t1;

  always_comb begin
    a_w  = 41'(s6_x) * signed'(41'(mobile_height_cm)) + 41'sd858993459200;
    dp_w = 51'(s6_y) * 51'(s6_ld);
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7_u  <= a_w[39:0];
      s7_dt <= dp_w[50:16];
      s7_t1 <= s6_t1;
    end
  end

  // stages 8 to 10: floor divide by 100, high part then low part
  logic [40:0]        ph_w;
  logic [13:0]        s8_qh;
  logic [19:0]        s8_uh;
  logic [19:0]        s8_ul;
  logic signed [35:0] s8_t2;

  assign ph_w = 41'(s7_u[39:20]) * 41'(hpl_pkg::RECIP100_20);

  always_ff @(posedge clk) begin
    if (en[8]) begin
      s8_qh <= ph_w[40:27];
      s8_uh <= s7_u[39:20];
      s8_ul <= s7_u[19:0];
      s8_t2 <= 36'(s7_t1) + 36'(s7_dt);
    end
  end

  logic [19:0]        rh_w;
  logic [13:0]        s9_qh;
  logic [26:0]        s9_v;
  logic signed [35:0] s9_t2;

  assign rh_w = s8_uh - 20'(s8_qh) * 20'd100;

  always_ff @(posedge clk) begin
    if (en[9]) begin
      s9_qh <= s8_qh;
      s9_v  <= {rh_w[6:0], s8_ul};
      s9_t2 <= s8_t2;
    end
  end

  logic [54:0]        pl_w;
  logic [13:0]        s10_qh;
  logic [19:0]        s10_ql;
  logic signed [35:0] s10_t2;

  assign pl_w = 55'(s9_v) * 55'(hpl_pkg::RECIP100_27);

  always_ff @(posedge clk) begin
    if (en[10]) begin
      s10_qh <= s9_qh;
      s10_ql <= pl_w[53:34];
      s10_t2 <= s9_t2;
    end
  end

  // stage 11: total, round to 1/256 dB (divide by 256 then by 100)
  logic signed [35:0] c_w, tot_w, t8_w, u2_w;
  logic [26:0]        s11_u2;

  always_comb begin
    c_w   = signed'(36'({s10_qh, s10_ql})) - 36'sd8589934592;
    tot_w = s10_t2 - c_w + 36'sd12800;
    t8_w  = tot_w >>> 8;
    u2_w  = t8_w + 36'sd104857600;
  end

  always_ff @(posedge clk) begin
    if (en[11]) begin
      s11_u2 <= u2_w[26:0];
    end
  end

  // stage 12: second divide by 100
  logic [54:0] p2_w;
  logic [20:0] s12_lr;

  assign p2_w = 55'(s11_u2) * 55'(hpl_pkg::RECIP100_27);

  always_ff @(posedge clk) begin
    if (en[12]) begin
      s12_lr <= p2_w[54:34];
    end
  end

  // stage 13: remove bias, saturate, output register
  logic signed [22:0] loss_w, rxf_w;
  logic signed [17:0] rx_sat;
  logic [15:0]        lq_sat;

  always_comb begin
    loss_w = signed'(23'(s12_lr)) - 23'sd1048576;
    rxf_w  = 23'(tx_d[S-1]) - loss_w;
    if (rxf_w < -23'sd131072) begin
      rx_sat = -18'sd131072;
    end else if (rxf_w > 23'sd32767) begin
      rx_sat = 18'sd32767;
    end else begin
      rx_sat = rxf_w[17:0];
    end
    if (loss_w < 23'sd0) begin
      lq_sat = '0;
    end else if (loss_w > 23'sd65535) begin
      lq_sat = 16'hffff;
    end else begin
      lq_sat = loss_w[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[S]) begin
      if (tc_d[S-1]) begin
        rx_power  <= 18'(tx_d[S-1]);
        loss_q8   <= '0;
        too_close <= 1'b1;
      end else begin
        rx_power  <= rx_sat;
        loss_q8   <= lq_sat;
        too_close <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_close_no_loss: assert property (@(posedge clk) disable iff (rst)
    out_valid && too_close |-> loss_q8 == 16'd0)
    else $error("loss reported on a too-close word");

  a_close_tx_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && too_close |-> rx_power[17:15] == 3'b000 || rx_power[17:15] == 3'b111)
    else $error("too-close rx power outside transmit range");

  a_flow: assert property (@(posedge clk) disable iff (rst)
    !out_stall |-> !in_stall)
    else $error("input stalled while output drains");

  a_close_flag: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && dist_cm <= DIST_BITS'(min_dist_cm) |=> tc_d[1])
    else $error("too-close flag lost at input stage");
`endif

endmodule

// File: design/hpl_ctrl.sv
module hpl_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [hpl_pkg::STAGES:1]    en
);

  logic [hpl_pkg::STAGES:1] vld;
  logic [hpl_pkg::STAGES:1] vld_next;

  // a stage loads when empty or when the one after it moves on
  always_comb begin
    en[hpl_pkg::STAGES] = !vld[hpl_pkg::STAGES] || !out_stall;
    for (int k = hpl_pkg::STAGES - 1; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_comb begin
    vld_next[1] = en[1] ? in_valid : vld[1];
    for (int k = 2; k <= hpl_pkg::STAGES; k++) begin
      vld_next[k] = en[k] ? vld[k-1] : vld[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  assign in_stall  = !en[1];
  assign out_valid = vld[hpl_pkg::STAGES];

endmodule

// File: design/hpl_log10.sv
module hpl_log10 #(
  parameter int XW    = 11,
  parameter int DEPTH = 256
) (
  input  logic                      clk,
  input  logic [3:0]                en,
  input  logic [XW-1:0]             x,
  output logic [$clog2(XW)+16:0]    lg
);

  localparam int PW = $clog2(XW);
  localparam int IW = $clog2(DEPTH);
  localparam int TW = $clog2(DEPTH + 1);
  localparam int LW = PW + 17;

  // log2(1 + i/DEPTH) in q16
  logic [16:0] tab [0:DEPTH];

  genvar gi;
  generate
    for (gi = 0; gi <= DEPTH; gi++) begin : g_tab
      localparam longint unsigned M0 =
        ((64'(DEPTH) + 64'(gi)) << 30) / 64'(DEPTH);
      if (gi == DEPTH) begin : g_top
        assign tab[gi] = 17'h10000;
      end else begin : g_sq
        assign tab[gi] = hpl_pkg::frac_sq(M0);
      end
    end
  endgenerate

  // stage a: leading one and normalised fraction
  logic [XW-1:0]    xs;
  logic [PW-1:0]    p_w;
  logic [XW+15:0]   sh_w;
  logic [PW-1:0]    a_p;
  logic [15:0]      a_f;

  always_comb begin
    xs  = (x == '0) ? XW'(1) : x;
    p_w = '0;
    for (int i = 0; i < XW; i++) begin
      if (xs[i]) begin
        p_w = PW'(i);
      end
    end
    sh_w = {xs, 16'h0000} >> p_w;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a_p <= p_w;
      a_f <= sh_w[15:0];
    end
  end

  // stage b: table lookup
  logic [31:0]   pos_w;
  logic [IW-1:0] idx_w;
  logic [PW-1:0] b_p;
  logic [16:0]   b_lo;
  logic [16:0]   b_hi;
  logic [15:0]   b_rem;

  always_comb begin
    pos_w = 32'(a_f) * 32'(DEPTH);
    idx_w = pos_w[16 +: IW];
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      b_p   <= a_p;
      b_lo  <= tab[TW'(idx_w)];
      b_hi  <= tab[TW'(idx_w) + TW'(1)];
      b_rem <= pos_w[15:0];
    end
  end

  // stage c: interpolation
  logic [16:0] dlt_w;
  logic [32:0] ip_w;
  logic [LW-1:0] c_l2;

  always_comb begin
    dlt_w = b_hi - b_lo;
    ip_w  = 33'(dlt_w) * 33'(b_rem);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      c_l2 <= LW'({b_p, 16'h0000}) + LW'(b_lo) + LW'(ip_w[32:16]);
    end
  end

  // stage d: scale to log10
  logic [LW+31:0] sc_w;

  always_comb begin
    sc_w = (LW+32)'(c_l2) * (LW+32)'(hpl_pkg::LOG10_2_Q32);
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      lg <= sc_w[32 +: LW];
    end
  end

endmodule
